// File: sv/bf_enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bf_enc_pkg;

  // Cipher geometry
  localparam int unsigned ROUNDS   = 16;
  localparam int unsigned P_DEPTH  = ROUNDS + 2;
  localparam int unsigned P_IDX_W  = $clog2(P_DEPTH);
  localparam int unsigned RND_W    = $clog2(ROUNDS);
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned S_BANKS  = 4;
  localparam int unsigned S_DEPTH  = 256;
  localparam int unsigned S_ADDR_W = $clog2(S_DEPTH);
  localparam int unsigned IDX_W    = 10;

  // Item commands
  typedef enum logic [1:0] {
    CMD_WR_P = 2'd0,
    CMD_WR_S = 2'd1,
    CMD_ENC  = 2'd2
  } cmd_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_XOR  = 4'b0010,
    ST_F    = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// File: sv/blowfish_block_encrypt_unit.sv
// Blowfish 64-bit block encryption unit.
// Input channel (in_valid_i / in_ready_o) carries one item per handshake:
// command_i selects a P-array word write, an S-box word write, or an
// encrypt of plain_block_i. Output channel (out_valid_o / out_ready_i)
// carries one cipher_block_o item per encrypt; writes produce no item.
// Write items complete on acceptance. An encrypt item runs on one shared
// round unit, each round a registered S-box read step followed by the F
// add/xor path, and ends in a whitening step that loads the result
// register. in_ready_o is low while an encrypt is in flight.
// A finished result sits in the output register; the unit accepts new
// items meanwhile, and a following encrypt waits in its whitening step
// until the output register is taken. Reset clears the sequencer and the
// output valid; the tables are not cleared and must be written before use.
// Bit 63..32 of each block is the left half.
`timescale 1ns / 1ps
`default_nettype none

module blowfish_block_encrypt_unit import bf_enc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [IDX_W-1:0]   table_index_i,
  input  wire logic [WORD_W-1:0]  table_word_i,
  input  wire logic [2*WORD_W-1:0] plain_block_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2*WORD_W-1:0]     cipher_block_o
);

  state_e              state_q, state_d;
  logic [RND_W-1:0]    rnd_q, rnd_d;
  logic [WORD_W-1:0]   l_q, l_d, r_q, r_d;
  logic [WORD_W-1:0]   l_x, f_val;
  logic [WORD_W-1:0]   p_q [P_DEPTH];
  logic [WORD_W-1:0]   s_rd_q [S_BANKS];
  logic                out_valid_q, out_valid_d;
  logic [2*WORD_W-1:0] cipher_q, cipher_d;
  logic                in_acc, wr_p, wr_s, enc_go, out_free, last_rnd;
  cmd_e                cmd;

  assign cmd      = cmd_e'(command_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign last_rnd = (rnd_q == RND_W'(ROUNDS - 1));

  // Decode accepted item
  always_comb begin
    wr_p   = 1'b0;
    wr_s   = 1'b0;
    enc_go = 1'b0;
    unique case (cmd)
      CMD_WR_P: wr_p   = in_acc && (table_index_i < IDX_W'(P_DEPTH));
      CMD_WR_S: wr_s   = in_acc;
      CMD_ENC:  enc_go = in_acc;
      default:  ;
    endcase
  end

  // P-array: one write port, round-indexed read plus the whitening reads
  always_ff @(posedge clk_i) begin
    if (wr_p) begin
      p_q[table_index_i[P_IDX_W-1:0]] <= table_word_i;
    end
  end

  assign l_x = l_q ^ p_q[{{(P_IDX_W-RND_W){1'b0}}, rnd_q}];

  // S-boxes: one bank per byte lane, registered read addressed by L ^ P[i]
  for (genvar b = 0; b < S_BANKS; b++) begin : g_sbox
    logic [WORD_W-1:0] mem_q [S_DEPTH];
    always_ff @(posedge clk_i) begin
      if (wr_s && (table_index_i[IDX_W-1:S_ADDR_W] == 2'(b))) begin
        mem_q[table_index_i[S_ADDR_W-1:0]] <= table_word_i;
      end
      s_rd_q[b] <= mem_q[l_x[WORD_W-1-BYTE_W*b -: BYTE_W]];
    end
  end

  // Round function on the registered S-box words
  assign f_val = ((s_rd_q[0] + s_rd_q[1]) ^ s_rd_q[2]) + s_rd_q[3];

  // Sequencer and round datapath
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    l_d         = l_q;
    r_d         = r_q;
    out_valid_d = out_valid_q;
    cipher_d    = cipher_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (enc_go) begin
          l_d     = plain_block_i[2*WORD_W-1:WORD_W];
          r_d     = plain_block_i[WORD_W-1:0];
          rnd_d   = '0;
          state_d = ST_XOR;
        end
      end
      ST_XOR: begin
        l_d     = l_x;
        state_d = ST_F;
      end
      ST_F: begin
        if (last_rnd) begin
          // drop the final swap
          r_d     = r_q ^ f_val;
          state_d = ST_FIN;
        end else begin
          l_d     = r_q ^ f_val;
          r_d     = l_q;
          rnd_d   = rnd_q + 1'b1;
          state_d = ST_XOR;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cipher_d    = {l_q ^ p_q[P_IDX_W'(ROUNDS + 1)], r_q ^ p_q[P_IDX_W'(ROUNDS)]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload without reset
  always_ff @(posedge clk_i) begin
    l_q      <= l_d;
    r_q      <= r_d;
    cipher_q <= cipher_d;
  end

  assign out_valid_o    = out_valid_q;
  assign cipher_block_o = cipher_q;

  // Checks
  a_enc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_ENC) |=> (state_q == ST_XOR && rnd_q == '0))
    else $error("encrypt item did not start the round sequence");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F && last_rnd) |=> (state_q == ST_FIN))
    else $error("last round did not lead to whitening");

  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the whitening step");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=>
      (state_q == ST_FIN && $stable(cipher_q)))
    else $error("pending result overwritten");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd != CMD_ENC) |=> (!$rose(out_valid_q) && state_q == ST_IDLE))
    else $error("write item produced a result");

endmodule

`default_nettype wire

// File: verif/blowfish_cipher_checker.sv
`timescale 1ns / 1ps

module blowfish_cipher_checker import bf_enc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            command_i,
  input  logic [IDX_W-1:0]      table_index_i,
  input  logic [WORD_W-1:0]     table_word_i,
  input  logic [2*WORD_W-1:0]   plain_block_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [2*WORD_W-1:0]   cipher_block_i,
  output int unsigned           pending_o,
  output int unsigned           checked_o,
  output int unsigned           mismatch_o
);

  // Shadow copy of the key tables
  logic [WORD_W-1:0]   p_key [P_DEPTH];
  logic [WORD_W-1:0]   s_box [S_BANKS*S_DEPTH];
  logic [2*WORD_W-1:0] cipher_expect_q [$];
  int unsigned         checked;
  int unsigned         mismatches;

  // Round function: four S-box lookups, one per byte of x
  function automatic logic [WORD_W-1:0] feistel_f(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = s_box[{2'd0, x[31:24]}] + s_box[{2'd1, x[23:16]}];
    y = y ^ s_box[{2'd2, x[15:8]}];
    y = y + s_box[{2'd3, x[7:0]}];
    return y;
  endfunction

  // Full block encryption with the current tables
  function automatic logic [2*WORD_W-1:0] encipher_block(input logic [2*WORD_W-1:0] blk);
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
    logic [WORD_W-1:0] hold;
    left  = blk[2*WORD_W-1:WORD_W];
    right = blk[WORD_W-1:0];
    for (int r = 0; r < ROUNDS; r++) begin
      left  = left ^ p_key[r];
      right = right ^ feistel_f(left);
      hold  = left;
      left  = right;
      right = hold;
    end
    // undo the last swap, then whiten
    hold  = left;
    left  = right;
    right = hold;
    right = right ^ p_key[ROUNDS];
    left  = left ^ p_key[ROUNDS+1];
    return {left, right};
  endfunction

  // Track accepted items, predict ciphertexts, compare results in order
  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [2*WORD_W-1:0] want;
    if (!rst_ni) begin
      cipher_expect_q.delete();
      checked    = 0;
      mismatches = 0;
      pending_o  <= 0;
      checked_o  <= 0;
      mismatch_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (command_i)
          CMD_WR_P: begin
            if (table_index_i < P_DEPTH) p_key[table_index_i] = table_word_i;
          end
          CMD_WR_S: begin
            s_box[table_index_i] = table_word_i;
          end
          CMD_ENC: begin
            cipher_expect_q.push_back(encipher_block(plain_block_i));
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (cipher_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: ciphertext %h arrived with nothing expected", cipher_block_i);
        end else begin
          want = cipher_expect_q.pop_front();
          checked++;
          if (cipher_block_i !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: ciphertext %0d: expected %h, got %h",
                       checked, want, cipher_block_i);
          end
        end
      end
      pending_o  <= cipher_expect_q.size();
      checked_o  <= checked;
      mismatch_o <= mismatches;
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bf_enc_pkg::*;

  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CALM_ITEMS   = 100;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i     = CMD_ENC;
  logic [IDX_W-1:0]    table_index_i = '0;
  logic [WORD_W-1:0]   table_word_i  = '0;
  logic [2*WORD_W-1:0] plain_block_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [2*WORD_W-1:0] cipher_block_o;

  int unsigned pending;
  int unsigned checked;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned n_p_writes  = 0;
  int unsigned n_s_writes  = 0;
  int unsigned n_encrypts  = 0;
  int unsigned n_spare     = 0;
  logic        calm        = 1'b0;

  blowfish_block_encrypt_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .table_index_i  (table_index_i),
    .table_word_i   (table_word_i),
    .plain_block_i  (plain_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cipher_block_o (cipher_block_o)
  );

  blowfish_cipher_checker cipher_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .table_index_i  (table_index_i),
    .table_word_i   (table_word_i),
    .plain_block_i  (plain_block_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cipher_block_i (cipher_block_o),
    .pending_o      (pending),
    .checked_o      (checked),
    .mismatch_o     (mismatches)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d ciphertexts outstanding",
               cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: stall in random bursts until the calm tail
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Offer one item, with an optional idle burst first, and hold it until taken
  task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] word,
                           input logic [2*WORD_W-1:0] blk);
    int unsigned gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    table_index_i <= idx;
    table_word_i  <= word;
    plain_block_i <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    case (cmd)
      CMD_WR_P: n_p_writes++;
      CMD_WR_S: n_s_writes++;
      CMD_ENC:  n_encrypts++;
      default:  n_spare++;
    endcase
  endtask

  // Hold off the sender until every ciphertext has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [2*WORD_W-1:0] rand_block();
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Load every table entry so no encrypt reads an unwritten one
    for (int i = 0; i < P_DEPTH; i++)
      send_item(CMD_WR_P, IDX_W'(i), $urandom, rand_block());
    for (int i = 0; i < S_BANKS*S_DEPTH; i++)
      send_item(CMD_WR_S, IDX_W'(i), $urandom, rand_block());

    // Directed: block extremes, ignored writes, table edge entries
    send_item(CMD_ENC, '0, '0, '0);
    send_item(CMD_ENC, '1, '1, '1);
    send_item(CMD_ENC, IDX_W'($urandom), $urandom, 64'h0000_0000_FFFF_FFFF);
    send_item(CMD_ENC, IDX_W'($urandom), $urandom, 64'hFFFF_FFFF_0000_0000);
    send_item(CMD_WR_P, IDX_W'(P_DEPTH), '1, rand_block());
    send_item(CMD_WR_P, '1, 32'hA5A5_5A5A, rand_block());
    send_item(CMD_ENC, '0, '0, 64'h0123_4567_89AB_CDEF);
    send_item(CMD_WR_P, '0, '0, '1);
    send_item(CMD_WR_P, IDX_W'(P_DEPTH-1), '1, '0);
    send_item(CMD_ENC, '0, '0, rand_block());
    send_item(CMD_WR_S, '0, '1, rand_block());
    send_item(CMD_WR_S, '1, '0, rand_block());
    send_item(CMD_ENC, '0, '0, '0);
    send_item(CMD_ENC, '0, '0, '1);
    send_item(CMD_SPARE, '1, '1, '1);
    send_item(CMD_SPARE, '0, '0, '0);
    send_item(CMD_ENC, '1, '1, rand_block());
    drain_results();

    // Random mix, mostly encrypts over a key that keeps changing
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_item(CMD_ENC, IDX_W'($urandom), $urandom, rand_block());
      else if (pick < 65)
        send_item(CMD_WR_P, IDX_W'($urandom_range(0, P_DEPTH-1)), $urandom, rand_block());
      else if (pick < 70)
        send_item(CMD_WR_P, IDX_W'($urandom), $urandom, rand_block());
      else if (pick < 94)
        send_item(CMD_WR_S, IDX_W'($urandom), $urandom, rand_block());
      else
        send_item(CMD_SPARE, IDX_W'($urandom), $urandom, rand_block());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d P-array writes, %0d S-box writes, %0d encrypts, %0d unused-command items",
             n_p_writes, n_s_writes, n_encrypts, n_spare);
    $display("Checked %0d ciphertexts: %0d mismatches, %0d still outstanding",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: blowfish_block_encrypt_unit.f
sv/bf_enc_pkg.sv
sv/blowfish_block_encrypt_unit.sv
verif/blowfish_cipher_checker.sv
verif/testbench.sv
